[rtl/banker_safety_allocator_macros.svh]
// Assertion macros for the banker safety allocator checker.
// Included by the checker file; no other dependencies.
`ifndef BANKER_SAFETY_ALLOCATOR_MACROS_SVH
`define BANKER_SAFETY_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsa: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define BSA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsa: next-cycle check failed");

`endif

[rtl/bsa_pkg.sv]
// Shared constants, codes and types for the banker safety allocator.
// No dependencies.
`timescale 1ns / 1ps
package bsa_pkg;
   localparam int MAX_PROCESSES = 8;
   localparam int MAX_RESOURCES = 4;
   localparam int COUNT_WIDTH   = 8;
   localparam int PID_W   = $clog2(MAX_PROCESSES);
   localparam int RID_W   = $clog2(MAX_RESOURCES);
   localparam int PCNT_W  = $clog2(MAX_PROCESSES + 1);
   localparam int RCNT_W  = $clog2(MAX_RESOURCES + 1);
   localparam int WORK_W  = COUNT_WIDTH + PCNT_W;
   localparam int REQ_FIELDS = 4;

   localparam logic [1:0] OP_AVAIL = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;
   localparam logic [1:0] OP_REQ   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_UNSAFE   = 3'd1;
   localparam logic [2:0] ST_NEED     = 3'd2;
   localparam logic [2:0] ST_AVAIL    = 3'd3;
   localparam logic [2:0] ST_LOAD_ERR = 3'd4;

   localparam logic CSR_PROC = 1'b0;
   localparam logic CSR_RES  = 1'b1;

   typedef logic [COUNT_WIDTH-1:0] cnt_type;
   typedef logic [WORK_W-1:0]      work_type;

   // One memory row: held and need counts of one process.
   typedef struct packed {
      cnt_type [MAX_RESOURCES-1:0] need;
      cnt_type [MAX_RESOURCES-1:0] held;
   } row_type;
endpackage

[rtl/banker_safety_allocator.sv]
// Banker safety allocator: request channel in, one status beat out per item.
// Depends on bsa_pkg.
`timescale 1ns / 1ps
// Usage
//  req_ beats carry one item: load a free count, load a process entry
//  (max claim and held), run a safety check, or a resource request.
//  Every item returns exactly one rsp_ beat with a status code and the
//  safe flag of the state left behind.
//  csr_ writes set the live process and resource counts; write only idle.
//  The safety walk reads one process row per cycle from the row memory
//  and runs up to N passes over the N live processes; a rejected-as-unsafe
//  request walks twice.  One item at a time: req_tready is high only
//  while the sequencer is idle.
//  Throughput is set by the single read port of the row memory.
//  Reset (synchronous, high) clears the free counts and marks every row
//  invalid (reads as zero); the counts reset to 8 processes, 4 resources.
//  The result sits in an output register; a new item is accepted while it
//  waits, and only the completion of that next item stalls on rsp_tready.
module banker_safety_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0] process_id[4:2] resource_id[6:5] amount[14:7]
   // held_amount[22:15] req_0[30:23] req_1[38:31] req_2[46:39] req_3[54:47]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0] safe[3]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [3:0]  csr_wdata
);
   import bsa_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MOD    = 3'd1;
   localparam logic [2:0] S_WINIT  = 3'd2;
   localparam logic [2:0] S_WRUN   = 3'd3;
   localparam logic [2:0] S_REVERT = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [3:0]             pc_ff;
   logic [2:0]             rc_ff;
   logic [1:0]             op_ff, op_in;
   logic [PID_W-1:0]       pid_ff, pid_in;
   logic [RID_W-1:0]       rid_ff, rid_in;
   cnt_type                amt_ff, amt_in, hamt_ff, hamt_in;
   cnt_type [MAX_RESOURCES-1:0] reqv_ff, reqv_in;
   cnt_type [MAX_RESOURCES-1:0] avail_ff, avail_in;
   work_type [MAX_RESOURCES-1:0] work_ff, work_in;
   logic [MAX_PROCESSES-1:0] fin_ff, fin_in;
   logic [MAX_PROCESSES-1:0] vld_ff, vld_in;
   logic [PCNT_W-1:0]      iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic [PID_W-1:0]       pendp_ff, pendp_in;
   logic                   prog_ff, prog_in;
   logic                   trial_ff, trial_in;
   logic [2:0]             status_ff, status_in;
   row_type                old_ff, old_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_safe_ff, rsp_safe_in;
   logic                   safe_ff, safe_in;

   // row memory
   row_type                mem [MAX_PROCESSES];
   row_type                rd_row_ff;
   logic                   rd_ok_ff;
   row_type                rd_row;
   logic                   mem_re, mem_we;
   logic [PID_W-1:0]       mem_raddr, mem_waddr;
   row_type                mem_wdata;

   logic [PCNT_W-1:0]      np;
   logic [RCNT_W-1:0]      nr;

   assign rd_row = rd_ok_ff ? rd_row_ff : '0;

   // live counts: zero reads as one, above maximum as maximum
   always_comb begin
      if (pc_ff == 4'd0) np = PCNT_W'(1);
      else if (32'(pc_ff) > MAX_PROCESSES) np = PCNT_W'(MAX_PROCESSES);
      else np = PCNT_W'(pc_ff);
      if (rc_ff == 3'd0) nr = RCNT_W'(1);
      else if (32'(rc_ff) > MAX_RESOURCES) nr = RCNT_W'(MAX_RESOURCES);
      else nr = RCNT_W'(rc_ff);
   end

   always_comb begin
      row_type  nrow;
      logic     ex_need, ex_av, fits, all_fin;
      logic     act;
      state_in      = state_ff;
      op_in         = op_ff;
      pid_in        = pid_ff;
      rid_in        = rid_ff;
      amt_in        = amt_ff;
      hamt_in       = hamt_ff;
      reqv_in       = reqv_ff;
      avail_in      = avail_ff;
      work_in       = work_ff;
      fin_in        = fin_ff;
      vld_in        = vld_ff;
      iss_in        = iss_ff;
      pend_in       = pend_ff;
      pendp_in      = pendp_ff;
      prog_in       = prog_ff;
      trial_in      = trial_ff;
      status_in     = status_ff;
      old_in        = old_ff;
      safe_in       = safe_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_safe_in   = rsp_safe_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      mem_we        = 1'b0;
      mem_waddr     = pid_ff;
      mem_wdata     = '0;
      nrow          = rd_row;
      ex_need       = 1'b0;
      ex_av         = 1'b0;
      fits          = 1'b1;
      all_fin       = 1'b1;
      act           = 1'b0;
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tdata[1:0];
               pid_in    = req_tdata[4:2];
               rid_in    = req_tdata[6:5];
               amt_in    = req_tdata[14:7];
               hamt_in   = req_tdata[22:15];
               for (int r = 0; r < MAX_RESOURCES; r++) begin
                  if (r < REQ_FIELDS) reqv_in[r] = req_tdata[23 + 8*r +: 8];
                  else reqv_in[r] = '0;
               end
               status_in = ST_OK;
               trial_in  = 1'b0;
               case (req_tdata[1:0])
                  OP_AVAIL: begin
                     avail_in[req_tdata[6:5]] = req_tdata[14:7];
                     state_in = S_WINIT;
                  end
                  OP_CHECK: state_in = S_WINIT;
                  default: begin
                     mem_re    = 1'b1;
                     mem_raddr = req_tdata[4:2];
                     state_in  = S_MOD;
                  end
               endcase
            end
         end
         S_MOD: begin
            state_in = S_WINIT;
            if (op_ff == OP_LOAD) begin
               nrow.held[rid_ff] = hamt_ff;
               if (hamt_ff > amt_ff) begin
                  nrow.need[rid_ff] = '0;
                  status_in = ST_LOAD_ERR;
               end else begin
                  nrow.need[rid_ff] = amt_ff - hamt_ff;
               end
               mem_we    = 1'b1;
               mem_wdata = nrow;
               vld_in[pid_ff] = 1'b1;
            end else if (PCNT_W'(pid_ff) >= np) begin
               status_in = ST_NEED;
            end else begin
               for (int r = 0; r < MAX_RESOURCES; r++) begin
                  act = (RCNT_W'(r) < nr);
                  if (act && reqv_ff[r] > rd_row.need[r]) ex_need = 1'b1;
                  if (act && reqv_ff[r] > avail_ff[r]) ex_av = 1'b1;
               end
               if (ex_need) status_in = ST_NEED;
               else if (ex_av) status_in = ST_AVAIL;
               else begin
                  for (int r = 0; r < MAX_RESOURCES; r++) begin
                     if (RCNT_W'(r) < nr) begin
                        nrow.held[r] = rd_row.held[r] + reqv_ff[r];
                        nrow.need[r] = rd_row.need[r] - reqv_ff[r];
                        avail_in[r]  = avail_ff[r] - reqv_ff[r];
                     end
                  end
                  old_in    = rd_row;
                  trial_in  = 1'b1;
                  mem_we    = 1'b1;
                  mem_wdata = nrow;
                  vld_in[pid_ff] = 1'b1;
               end
            end
         end
         S_WINIT: begin
            for (int r = 0; r < MAX_RESOURCES; r++) work_in[r] = WORK_W'(avail_ff[r]);
            fin_in   = '0;
            iss_in   = '0;
            pend_in  = 1'b0;
            prog_in  = 1'b0;
            state_in = S_WRUN;
         end
         S_WRUN: begin
            // issue one row read per cycle, evaluate the row read last cycle
            if (iss_ff < np) begin
               mem_re    = 1'b1;
               mem_raddr = iss_ff[PID_W-1:0];
               pend_in   = 1'b1;
               pendp_in  = iss_ff[PID_W-1:0];
               iss_in    = iss_ff + PCNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               for (int r = 0; r < MAX_RESOURCES; r++)
                  if (RCNT_W'(r) < nr && WORK_W'(rd_row.need[r]) > work_ff[r]) fits = 1'b0;
               if (!fin_ff[pendp_ff] && fits) begin
                  for (int r = 0; r < MAX_RESOURCES; r++)
                     if (RCNT_W'(r) < nr) work_in[r] = work_ff[r] + WORK_W'(rd_row.held[r]);
                  fin_in[pendp_ff] = 1'b1;
                  prog_in = 1'b1;
               end
            end
            if (iss_ff >= np && !pend_ff) begin
               for (int p = 0; p < MAX_PROCESSES; p++)
                  if (PCNT_W'(p) < np && !fin_ff[p]) all_fin = 1'b0;
               if (prog_ff && !all_fin) begin
                  iss_in  = '0;
                  prog_in = 1'b0;
               end else if (trial_ff && !all_fin) begin
                  state_in = S_REVERT;
               end else begin
                  safe_in  = all_fin;
                  trial_in = 1'b0;
                  state_in = S_DONE;
               end
            end
         end
         S_REVERT: begin
            mem_we    = 1'b1;
            mem_wdata = old_ff;
            for (int r = 0; r < MAX_RESOURCES; r++)
               if (RCNT_W'(r) < nr) avail_in[r] = avail_ff[r] + reqv_ff[r];
            status_in = ST_UNSAFE;
            trial_in  = 1'b0;
            state_in  = S_WINIT;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_safe_in   = safe_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) begin
         rd_row_ff <= mem[mem_raddr];
         rd_ok_ff  <= vld_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 4'(MAX_PROCESSES);
         rc_ff        <= 3'(MAX_RESOURCES);
         avail_ff     <= '0;
         vld_ff       <= '0;
         fin_ff       <= '0;
         trial_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avail_ff     <= avail_in;
         vld_ff       <= vld_in;
         fin_ff       <= fin_in;
         trial_ff     <= trial_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_PROC: pc_ff <= csr_wdata;
               CSR_RES:  rc_ff <= csr_wdata[2:0];
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      rid_ff        <= rid_in;
      amt_ff        <= amt_in;
      hamt_ff       <= hamt_in;
      reqv_ff       <= reqv_in;
      work_ff       <= work_in;
      iss_ff        <= iss_in;
      pendp_ff      <= pendp_in;
      prog_ff       <= prog_in;
      status_ff     <= status_in;
      old_ff        <= old_in;
      safe_ff       <= safe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_safe_ff   <= rsp_safe_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_safe_ff, rsp_status_ff};
endmodule

[rtl/bsa_checker.sv]
// Port-level checker for the banker safety allocator, bound to the top level.
// Depends on banker_safety_allocator_macros.svh.
`timescale 1ns / 1ps
`include "banker_safety_allocator_macros.svh"
module bsa_port_props (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   // a stalled result beat holds
   `BSA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // status is one of the defined codes
   `BSA_ASSERT_IMP(a_status_range, clock, reset, rsp_tvalid, rsp_tdata[2:0] <= 3'd4)
   // padding bits stay zero
   `BSA_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:4] == 4'd0)
   // one item in flight: no accept in the cycle after an accept
   `BSA_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

bind banker_safety_allocator bsa_port_props u_bsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/bsa_checker.sv]
// Scoreboard for the banker safety allocator: watches request, result and csr ports.
// Mirrors the allocator state and checks each result beat. Depends on bsa_pkg.
`timescale 1ns / 1ps
module bsa_checker
   import bsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [3:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic [2:0] status;
      logic       safe;
   } verdict_type;

   logic [3:0]    proc_reg;
   logic [2:0]    res_reg;
   cnt_type       free_cnt [MAX_RESOURCES];
   cnt_type       held_cnt [MAX_PROCESSES][MAX_RESOURCES];
   cnt_type       need_cnt [MAX_PROCESSES][MAX_RESOURCES];
   verdict_type   verdicts [$];

   function automatic int live_procs();
      if (proc_reg == 0) return 1;
      if (proc_reg > MAX_PROCESSES) return MAX_PROCESSES;
      return int'(proc_reg);
   endfunction

   function automatic int live_res();
      if (res_reg == 0) return 1;
      if (res_reg > MAX_RESOURCES) return MAX_RESOURCES;
      return int'(res_reg);
   endfunction

   // Classic banker walk: retire any process whose need fits in the work vector.
   function automatic bit state_is_safe();
      int  work [MAX_RESOURCES];
      bit  done [MAX_PROCESSES];
      bit  progress;
      bit  fits;
      int  np;
      int  nr;
      np = live_procs();
      nr = live_res();
      for (int r = 0; r < MAX_RESOURCES; r++) work[r] = int'(free_cnt[r]);
      for (int p = 0; p < MAX_PROCESSES; p++) done[p] = 0;
      progress = 1;
      while (progress) begin
         progress = 0;
         for (int p = 0; p < np; p++) begin
            if (!done[p]) begin
               fits = 1;
               for (int r = 0; r < nr; r++)
                  if (int'(need_cnt[p][r]) > work[r]) fits = 0;
               if (fits) begin
                  for (int r = 0; r < nr; r++) work[r] += int'(held_cnt[p][r]);
                  done[p] = 1;
                  progress = 1;
               end
            end
         end
      end
      for (int p = 0; p < np; p++)
         if (!done[p]) return 0;
      return 1;
   endfunction

   function automatic verdict_type allocate(logic [55:0] d);
      logic [1:0]  op;
      logic [2:0]  pid;
      logic [1:0]  rid;
      cnt_type     amt;
      cnt_type     held;
      cnt_type     ask [MAX_RESOURCES];
      logic [2:0]  st;
      int          nr;
      verdict_type v;
      op   = d[1:0];
      pid  = d[4:2];
      rid  = d[6:5];
      amt  = d[14:7];
      held = d[22:15];
      for (int r = 0; r < MAX_RESOURCES; r++) ask[r] = d[23 + 8*r +: 8];
      st = ST_OK;
      nr = live_res();
      case (op)
         OP_AVAIL: free_cnt[rid] = amt;
         OP_LOAD: begin
            held_cnt[pid][rid] = held;
            if (held > amt) begin
               need_cnt[pid][rid] = '0;
               st = ST_LOAD_ERR;
            end else
               need_cnt[pid][rid] = amt - held;
         end
         OP_REQ: begin
            if (int'(pid) >= live_procs()) st = ST_NEED;
            else begin
               for (int r = 0; r < nr; r++)
                  if (ask[r] > need_cnt[pid][r]) st = ST_NEED;
               if (st == ST_OK)
                  for (int r = 0; r < nr; r++)
                     if (ask[r] > free_cnt[r]) st = ST_AVAIL;
               if (st == ST_OK) begin
                  // tentative grant, rolled back if it leaves no safe order
                  for (int r = 0; r < nr; r++) begin
                     free_cnt[r]      -= ask[r];
                     held_cnt[pid][r] += ask[r];
                     need_cnt[pid][r] -= ask[r];
                  end
                  if (!state_is_safe()) begin
                     for (int r = 0; r < nr; r++) begin
                        free_cnt[r]      += ask[r];
                        held_cnt[pid][r] -= ask[r];
                        need_cnt[pid][r] += ask[r];
                     end
                     st = ST_UNSAFE;
                  end
               end
            end
         end
         default: ;
      endcase
      v.status = st;
      v.safe   = state_is_safe();
      return v;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t bsa mismatch: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         proc_reg   = 4'(MAX_PROCESSES);
         res_reg    = 3'(MAX_RESOURCES);
         fail_count = 0;
         for (int r = 0; r < MAX_RESOURCES; r++) free_cnt[r] = '0;
         for (int p = 0; p < MAX_PROCESSES; p++)
            for (int r = 0; r < MAX_RESOURCES; r++) begin
               held_cnt[p][r] = '0;
               need_cnt[p][r] = '0;
            end
         verdicts.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_PROC) proc_reg = csr_wdata;
            else res_reg = csr_wdata[2:0];
         end
         if (req_tvalid && req_tready) verdicts.push_back(allocate(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts.size() == 0) report("unexpected beat", int'(rsp_tdata), 0);
            else begin
               want = verdicts.pop_front();
               if (rsp_tdata[2:0] != want.status)
                  report("status", int'(rsp_tdata[2:0]), int'(want.status));
               if (rsp_tdata[3] != want.safe)
                  report("safe", int'(rsp_tdata[3]), int'(want.safe));
            end
         end
      end
      pending = verdicts.size();
   end
endmodule

[tb/sv/tb.sv]
// Top of the banker safety allocator bench: clock, reset, stimulus and verdict.
// Depends on bsa_pkg, banker_safety_allocator and bsa_checker.
`timescale 1ns / 1ps
module tb;
   import bsa_pkg::*;

   localparam int RAND_PER_PHASE = 375;
   localparam int STALL_LIMIT    = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 0;
   logic        csr_addr = CSR_PROC;
   logic [3:0]  csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic        req_taken = 0;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   banker_safety_allocator u_dut (.*);

   bsa_checker u_chk (.*);

   // handshake flag sampled at the edge, read by the stimulus at the next falling edge
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // watchdog: nothing moved for far longer than a double walk under stall
   always @(posedge clock)
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** banker_safety_allocator: FAILED **");
         $finish;
      end

   function automatic logic [55:0] pack_item(logic [1:0] op, logic [2:0] pid,
         logic [1:0] rid, logic [7:0] amt, logic [7:0] held,
         logic [7:0] q0, logic [7:0] q1, logic [7:0] q2, logic [7:0] q3);
      return {1'b0, q3, q2, q1, q0, held, amt, rid, pid, op};
   endfunction

   // one request beat; valid drops after the accepting edge
   task automatic send(logic [55:0] d);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata  = d;
      do @(negedge clock); while (!req_taken);
      req_tvalid = 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [3:0] val);
      csr_we    = 1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic logic [7:0] small_or_full(int hi);
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(hi));
   endfunction

   task automatic random_item(int np);
      int         pick;
      logic [2:0] pid;
      logic [7:0] mx;
      pick = $urandom_range(99);
      pid  = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(np - 1));
      if (pick < 15)
         send(pack_item(OP_AVAIL, 3'($urandom), 2'($urandom), small_or_full(12),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom)));
      else if (pick < 45) begin
         mx = small_or_full(10);
         send(pack_item(OP_LOAD, pid, 2'($urandom), mx,
                        ($urandom_range(7) == 0) ? small_or_full(12)
                                                 : 8'($urandom_range(int'(mx))),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (pick < 55)
         send(pack_item(OP_CHECK, 3'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      else
         send(pack_item(OP_REQ, pid, 2'($urandom), 8'($urandom), 8'($urandom),
                        small_or_full(3), small_or_full(3), small_or_full(3),
                        small_or_full(3)));
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 0;

      // directed: extremes, load error, each rejection, unsafe rollback
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send(pack_item(OP_CHECK, 3'd0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send(pack_item(OP_AVAIL, 3'd7, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send(pack_item(OP_AVAIL, 3'd0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // held above max
      send(pack_item(OP_LOAD, 3'd7, 2'd3, 8'h10, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      // held equal max
      send(pack_item(OP_LOAD, 3'd7, 2'd3, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      send(pack_item(OP_LOAD, 3'd0, 2'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // beyond free
      send(pack_item(OP_REQ, 3'd0, 2'd0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
      // beyond need
      send(pack_item(OP_REQ, 3'd1, 2'd0, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
      send(pack_item(OP_AVAIL, 3'd0, 2'd0, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send(pack_item(OP_LOAD, 3'd1, 2'd0, 8'h06, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00));
      // leaves nothing: unsafe
      send(pack_item(OP_REQ, 3'd0, 2'd0, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00));
      // also unsafe: process 0 still cannot finish
      send(pack_item(OP_REQ, 3'd1, 2'd0, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00));
      send(pack_item(OP_REQ, 3'd7, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
      send(pack_item(OP_CHECK, 3'd0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain();
      write_csr(CSR_PROC, 4'd2);
      write_csr(CSR_RES, 4'd1);
      // stored while inactive
      send(pack_item(OP_LOAD, 3'd6, 2'd2, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
      // inactive process
      send(pack_item(OP_REQ, 3'd5, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // unused fields
      send(pack_item(OP_REQ, 3'd1, 2'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
      send(pack_item(OP_CHECK, 3'd0, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain();

      // random phases; csr values cover zero, in range and above range
      for (int ph = 0; ph < 4; ph++) begin
         logic [3:0] pv;
         logic [2:0] rv;
         int         np;
         case (ph)
            0: begin pv = 4'd8;  rv = 3'd4; end
            1: begin pv = 4'd0;  rv = 3'd7; end
            2: begin pv = 4'd15; rv = 3'd0; end
            default: begin pv = 4'd3; rv = 3'd2; end
         endcase
         write_csr(CSR_PROC, pv);
         write_csr(CSR_RES, {1'b0, rv});
         np = (pv == 0) ? 1 : (pv > 8) ? 8 : int'(pv);
         tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 65 : 0;
         rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 38 : 0;
         for (int i = 0; i < RAND_PER_PHASE; i++) begin
            random_item(np);
            if (i == RAND_PER_PHASE / 2) drain();   // hold off until all results are in
         end
         drain();
      end

      repeat (200) @(negedge clock);
      if (fail_count == 0)
         $display("** banker_safety_allocator: PASSED **");
      else
         $display("** banker_safety_allocator: FAILED **");
      $finish;
   end
endmodule
